// ===== rtl/pta_pkg.sv =====
package pta_pkg;

  // Default build of the block
  localparam int SEGMENTS_DEF     = 64;
  localparam int SAMPLE_WIDTH_DEF = 16;

  // Register map
  localparam int          APB_ADDR_W        = 3;
  localparam int          APB_DATA_W        = 32;
  localparam logic [0:0]  REG_PENALTY_SLOPE = 1'b0;
  localparam int          SLOPE_RESET       = 1024;

  // Q30 helpers for building the tanh breakpoints at elaboration
  localparam int               Q30   = 30;
  localparam longint unsigned  ONE30 = 64'd1 << Q30;

  // Restoring division, one quotient bit per iteration
  function automatic longint unsigned udiv64(longint unsigned num, longint unsigned den);
    longint unsigned quo;
    longint unsigned rem;
    quo = '0;
    rem = '0;
    for (int i = 63; i >= 0; i--) begin
      rem = {rem[62:0], num[i]};
      if (rem >= den) begin
        rem    = rem - den;
        quo[i] = 1'b1;
      end
    end
    return quo;
  endfunction

  // Truncating Q30 product
  function automatic longint unsigned mul_q30(longint unsigned a, longint unsigned b);
    longint unsigned hi;
    longint unsigned lo;
    hi = a >> Q30;
    lo = a & (ONE30 - 64'd1);
    return hi * b + ((lo * b) >> Q30);
  endfunction

  // Breakpoint k of tanh over [0, 4] in Q4.frac, kept non-decreasing
  function automatic longint tanh_knot(int k, int segs, int frac);
    longint unsigned t;
    longint unsigned term;
    longint unsigned r;
    longint unsigned e;
    longint unsigned den;
    longint unsigned q;
    longint          v;
    longint          best;
    t    = udiv64(64'd8 << Q30, longint'(segs));
    term = ONE30;
    r    = ONE30;
    e    = ONE30;
    best = 0;
    // exp(8/segs) as a truncated Taylor sum
    for (int n = 1; n <= 24; n++) begin
      term = udiv64((term * t) >> Q30, longint'(n));
      r    = r + term;
    end
    for (int j = 0; j <= k; j++) begin
      if (j > 0) begin
        e = mul_q30(e, r);
      end
      den = e + ONE30;
      q   = udiv64((64'd2 << (Q30 + frac)) + (den >> 1), den);
      v   = (64'sd1 <<< frac) - longint'(q);
      if (j > 0 && v < best) begin
        v = best;
      end
      best = v;
    end
    return best;
  endfunction

endpackage

// ===== rtl/pta_tanh.sv =====
module pta_tanh #(
  parameter int SEGMENTS     = pta_pkg::SEGMENTS_DEF,
  parameter int SAMPLE_WIDTH = pta_pkg::SAMPLE_WIDTH_DEF
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic [SAMPLE_WIDTH-1:0] feature_i,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic                    neg_o,
  output logic [SAMPLE_WIDTH-4:0] tanh_o
);
  import pta_pkg::*;

  localparam int FRAC = SAMPLE_WIDTH - 4;
  localparam int SPAN = SAMPLE_WIDTH - 2;   // fraction bits of the position in a segment
  localparam int KW   = FRAC + 1;           // breakpoint width, holds 0 .. one
  localparam int IW   = $clog2(SEGMENTS);
  localparam int PW   = SPAN + IW;
  localparam int MW   = KW + SPAN;

  localparam logic [KW-1:0]  ONE_Q  = {1'b1, {FRAC{1'b0}}};
  localparam logic [MW:0]    HALF_R = (MW + 1)'(1) << (SPAN - 1);

  // Breakpoint and step tables, built at elaboration
  logic [KW-1:0] base_tbl [SEGMENTS];
  logic [KW-1:0] diff_tbl [SEGMENTS];

  for (genvar k = 0; k < SEGMENTS; k++) begin : g_knot
    localparam longint KLO = tanh_knot(k, SEGMENTS, FRAC);
    localparam longint KHI = tanh_knot(k + 1, SEGMENTS, FRAC);
    assign base_tbl[k] = KW'(KLO);
    assign diff_tbl[k] = KW'(KHI - KLO);
  end

  // Stage advance, a bubble in a later stage lets earlier ones move
  logic v1_q, v2_q, v3_q, v4_q;
  logic adv1, adv2, adv3, adv4;

  assign adv4 = !v4_q || !out_stall_i;
  assign adv3 = !v3_q || adv4;
  assign adv2 = !v2_q || adv3;
  assign adv1 = !v1_q || adv2;
  assign in_stall_o = !adv1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (adv1) v1_q <= in_valid_i;
      if (adv2) v2_q <= v1_q;
      if (adv3) v3_q <= v2_q;
      if (adv4) v4_q <= v3_q;
    end
  end

  // Stage 1: magnitude, sign, segment index and offset
  logic [SAMPLE_WIDTH-1:0] mag;
  logic [PW-1:0]           pos;
  logic                    neg1_d, sat1_d;
  logic [IW-1:0]           idx1_q;
  logic [SPAN-1:0]         rem1_q;
  logic                    neg1_q, sat1_q;

  always_comb begin
    mag    = feature_i[SAMPLE_WIDTH-1] ? (~feature_i + 1'b1) : feature_i;
    neg1_d = feature_i[SAMPLE_WIDTH-1] || (feature_i == '0);
    sat1_d = |mag[SAMPLE_WIDTH-1:SPAN];   // |x| at least 4
    pos    = PW'(mag[SPAN-1:0]) * PW'(SEGMENTS);
  end

  always_ff @(posedge clk_i) begin
    if (adv1) begin
      idx1_q <= pos[PW-1:SPAN];
      rem1_q <= pos[SPAN-1:0];
      neg1_q <= neg1_d;
      sat1_q <= sat1_d;
    end
  end

  // Stage 2: table read
  logic [KW-1:0]   base2_q, diff2_q;
  logic [SPAN-1:0] rem2_q;
  logic            neg2_q, sat2_q;

  always_ff @(posedge clk_i) begin
    if (adv2) begin
      base2_q <= base_tbl[idx1_q];
      diff2_q <= diff_tbl[idx1_q];
      rem2_q  <= rem1_q;
      neg2_q  <= neg1_q;
      sat2_q  <= sat1_q;
    end
  end

  // Stage 3: step times offset
  logic [MW-1:0] mult3_q;
  logic [KW-1:0] base3_q;
  logic          neg3_q, sat3_q;

  always_ff @(posedge clk_i) begin
    if (adv3) begin
      mult3_q <= MW'(diff2_q) * MW'(rem2_q);
      base3_q <= base2_q;
      neg3_q  <= neg2_q;
      sat3_q  <= sat2_q;
    end
  end

  // Stage 4: rounded interpolation, saturate to one beyond the table
  logic [MW:0]   interp;
  logic [KW-1:0] tanh4_d, tanh4_q;
  logic          neg4_q;

  always_comb begin
    interp  = (MW + 1)'(mult3_q) + HALF_R;
    tanh4_d = sat3_q ? ONE_Q : (base3_q + KW'(interp >> SPAN));
  end

  always_ff @(posedge clk_i) begin
    if (adv4) begin
      tanh4_q <= tanh4_d;
      neg4_q  <= neg3_q;
    end
  end

  assign out_valid_o = v4_q;
  assign neg_o       = neg4_q;
  assign tanh_o      = tanh4_q;

endmodule

// ===== rtl/penalized_tanh_activation.sv =====
// Penalized tanh on signed Q4.F samples (F = SAMPLE_WIDTH - 4): positive
// samples give tanh(x), zero and negative samples give penalty_slope * tanh(x),
// rounded to nearest (ties up) and saturated. tanh is interpolated between
// SEGMENTS + 1 constant breakpoints over |x| < 4 and is one beyond. The block
// takes one item per clock when not stalled, in a six-stage pipeline (magnitude
// and segment, table read, slope multiply, interpolation add, penalty multiply,
// round and saturate); out_stall_i holds the output register and the stall
// reaches the input only once every stage is full. penalty_slope (byte address
// 0) must be written by the user only while idle; the block does not enforce it.
module penalized_tanh_activation #(
  parameter int SEGMENTS     = pta_pkg::SEGMENTS_DEF,
  parameter int SAMPLE_WIDTH = pta_pkg::SAMPLE_WIDTH_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // sample input
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic signed [SAMPLE_WIDTH-1:0]  feature_i,
  // result output
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic signed [SAMPLE_WIDTH-1:0]  activation_o,
  // register port
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [pta_pkg::APB_ADDR_W-1:0]  paddr,
  input  logic [pta_pkg::APB_DATA_W-1:0]  pwdata,
  output logic [pta_pkg::APB_DATA_W-1:0]  prdata,
  output logic                            pready
);
  import pta_pkg::*;

  localparam int FRAC = SAMPLE_WIDTH - 4;
  localparam int KW   = FRAC + 1;
  localparam int PRW  = SAMPLE_WIDTH + KW + 1;   // penalty product width

  localparam logic signed [PRW:0] HALF_P = (PRW + 1)'(1) <<< (FRAC - 1);
  localparam logic signed [PRW:0] SMAX_X = ((PRW + 1)'(1) <<< (SAMPLE_WIDTH - 1)) - 1'b1;
  localparam logic signed [PRW:0] SMIN_X = -SMAX_X - 1'b1;

  // Register port
  logic signed [SAMPLE_WIDTH-1:0] slope_q;

  assign pready = 1'b1;
  assign prdata = APB_DATA_W'(slope_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slope_q <= SAMPLE_WIDTH'(SLOPE_RESET);
    end else if (psel && penable && pwrite && (paddr[2] == REG_PENALTY_SLOPE)) begin
      slope_q <= pwdata[SAMPLE_WIDTH-1:0];
    end
  end

  // Stages 1 to 4: tanh of the magnitude
  logic          th_valid, th_stall, th_neg;
  logic [KW-1:0] th_mag;

  pta_tanh #(
    .SEGMENTS     (SEGMENTS),
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
  ) u_tanh (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .feature_i   (feature_i),
    .out_valid_o (th_valid),
    .out_stall_i (th_stall),
    .neg_o       (th_neg),
    .tanh_o      (th_mag)
  );

  // Stage advance for the back end
  logic v5_q, v6_q;
  logic adv5, adv6;

  assign adv6     = !v6_q || !out_stall_i;
  assign adv5     = !v5_q || adv6;
  assign th_stall = !adv5;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v5_q <= 1'b0;
      v6_q <= 1'b0;
    end else begin
      if (adv5) v5_q <= th_valid;
      if (adv6) v6_q <= v5_q;
    end
  end

  // Stage 5: slope times -tanh
  logic signed [PRW-1:0] neg_th;
  logic signed [PRW-1:0] prod5_q;
  logic [KW-1:0]         th5_q;
  logic                  neg5_q;

  assign neg_th = -PRW'($signed({1'b0, th_mag}));

  always_ff @(posedge clk_i) begin
    if (adv5) begin
      prod5_q <= PRW'(slope_q) * neg_th;
      th5_q   <= th_mag;
      neg5_q  <= th_neg;
    end
  end

  // Stage 6: round, saturate, pick the branch
  logic signed [PRW:0]            rnd;
  logic signed [SAMPLE_WIDTH-1:0] res6_d, res6_q;
  logic                           neg6_q;

  always_comb begin
    rnd = ((PRW + 1)'(prod5_q) + HALF_P) >>> FRAC;
    priority if (!neg5_q) begin
      res6_d = SAMPLE_WIDTH'(th5_q);
    end else if (rnd > SMAX_X) begin
      res6_d = SMAX_X[SAMPLE_WIDTH-1:0];
    end else if (rnd < SMIN_X) begin
      res6_d = SMIN_X[SAMPLE_WIDTH-1:0];
    end else begin
      res6_d = rnd[SAMPLE_WIDTH-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv6) begin
      res6_q <= res6_d;
      neg6_q <= neg5_q;
    end
  end

  assign out_valid_o  = v6_q;
  assign activation_o = res6_q;

  // The input stalls only when the whole pipeline is full and held
  a_stall_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i && v5_q && th_valid))
    else $error("input stalled with room in the pipeline");

  // A positive sample never yields more than one or less than zero
  a_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !neg6_q) |->
      (activation_o >= 0 && activation_o <= $signed(SAMPLE_WIDTH'(1) << FRAC)))
    else $error("positive branch out of range");

  // A held result keeps its value
  a_hold_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> $stable(activation_o))
    else $error("held result changed");

endmodule

// ===== test/penalized_tanh_activation_test.sv =====
`timescale 1ns / 100ps

module penalized_tanh_activation_test;

  import pta_pkg::*;

  localparam int W           = SAMPLE_WIDTH_DEF;
  localparam int SEGS        = SEGMENTS_DEF;
  localparam int FRAC        = W - 4;
  localparam int SPAN        = FRAC + 2;
  localparam int LATENCY     = 6;
  localparam int CYCLE_LIMIT = 200000;
  localparam int IDLE_PCT    = 34;
  localparam int PHASE_ITEMS = 100;

  localparam logic [APB_ADDR_W-1:0] SLOPE_ADDR    = APB_ADDR_W'(4 * REG_PENALTY_SLOPE);
  // first address past the register list
  localparam logic [APB_ADDR_W-1:0] UNMAPPED_ADDR = APB_ADDR_W'(4 * (REG_PENALTY_SLOPE + 1));

  logic                  clk_i;
  logic                  rst_n     = 1'b0;
  logic                  in_valid  = 1'b0;
  logic signed [W-1:0]   feature   = '0;
  logic                  out_stall = 1'b0;
  logic                  psel      = 1'b0;
  logic                  penable   = 1'b0;
  logic                  pwrite    = 1'b0;
  logic [APB_ADDR_W-1:0] paddr     = '0;
  logic [APB_DATA_W-1:0] pwdata    = '0;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;
  logic                  in_stall_o;
  logic                  out_valid_o;
  logic signed [W-1:0]   activation_o;

  // predictor state
  longint              tanh_knot_q [0:SEGS];
  logic signed [W-1:0] slope_q;
  logic signed [W-1:0] expected_activation [$];

  bit idling_on   = 1'b1;
  int errors      = 0;
  int cycle_count = 0;

  penalized_tanh_activation dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall_o),
    .feature_i   (feature),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall),
    .activation_o(activation_o),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // run limit
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // tanh breakpoints over [0, 4]: exp by Taylor sum in Q30, then 1 - 2/(e^2x + 1)
  function automatic void build_tanh_knots();
    longint unsigned one30;
    longint unsigned step;
    longint unsigned term;
    longint unsigned ratio;
    longint unsigned pow;
    longint unsigned den;
    longint unsigned quo;
    longint          v;
    one30 = 64'd1 << 30;
    step  = (64'd8 << 30) / 64'(SEGS);
    term  = one30;
    ratio = one30;
    pow   = one30;
    for (int n = 1; n <= 24; n++) begin
      term  = ((term * step) >> 30) / 64'(n);
      ratio = ratio + term;
    end
    for (int k = 0; k <= SEGS; k++) begin
      if (k > 0) begin
        pow = (pow >> 30) * ratio + (((pow & (one30 - 64'd1)) * ratio) >> 30);
      end
      den = pow + one30;
      quo = ((64'd2 << (30 + FRAC)) + den / 64'd2) / den;
      v   = (64'sd1 <<< FRAC) - longint'(quo);
      // keep the table monotonic
      if (k > 0 && v < tanh_knot_q[k-1]) begin
        v = tanh_knot_q[k-1];
      end
      tanh_knot_q[k] = v;
    end
  endfunction

  // interpolated tanh of a magnitude in Q4.F, exactly one at 4.0 and above
  function automatic longint tanh_of_mag(longint mag);
    longint p;
    longint idx;
    longint rem;
    longint diff;
    if (mag >= (64'sd1 <<< SPAN)) begin
      return 64'sd1 <<< FRAC;
    end
    p    = mag * SEGS;
    idx  = p >>> SPAN;
    rem  = p & ((64'sd1 <<< SPAN) - 1);
    diff = tanh_knot_q[idx+1] - tanh_knot_q[idx];
    return tanh_knot_q[idx] + ((diff * rem + (64'sd1 <<< (SPAN - 1))) >>> SPAN);
  endfunction

  function automatic logic signed [W-1:0] penalized_tanh(logic signed [W-1:0] x,
                                                         logic signed [W-1:0] slope);
    longint xv;
    longint res;
    xv = longint'(x);
    if (xv > 0) begin
      res = tanh_of_mag(xv);
    end else begin
      // round half up, then saturate
      res = (longint'(slope) * -tanh_of_mag(-xv) + (64'sd1 <<< (FRAC - 1))) >>> FRAC;
    end
    if (res > (64'sd1 <<< (W - 1)) - 1) res = (64'sd1 <<< (W - 1)) - 1;
    if (res < -(64'sd1 <<< (W - 1)))    res = -(64'sd1 <<< (W - 1));
    return res[W-1:0];
  endfunction

  task automatic report_error(string msg);
    errors++;
    if (errors <= 10) begin
      $display("%0t: %s", $realtime, msg);
    end
  endtask

  // result checker
  always @(posedge clk_i) begin
    logic signed [W-1:0] want;
    if (rst_n && out_valid_o && !out_stall) begin
      if (expected_activation.size() == 0) begin
        report_error($sformatf("unexpected activation %0d", activation_o));
      end else begin
        want = expected_activation.pop_front();
        if (activation_o !== want) begin
          report_error($sformatf("activation expected %0d, got %0d", want, activation_o));
        end
      end
    end
  end

  // receiver stalls at random
  always @(negedge clk_i) begin
    out_stall <= idling_on && ($urandom_range(99) < IDLE_PCT);
  end

  task automatic send_feature(logic signed [W-1:0] x);
    while (idling_on && $urandom_range(99) < IDLE_PCT) begin
      @(negedge clk_i);
      in_valid <= 1'b0;
    end
    @(negedge clk_i);
    in_valid <= 1'b1;
    feature  <= x;
    do @(posedge clk_i); while (in_stall_o);
    expected_activation.push_back(penalized_tanh(x, slope_q));
  endtask

  task automatic drain_pipeline();
    @(negedge clk_i);
    in_valid <= 1'b0;
    while (expected_activation.size() != 0) @(posedge clk_i);
  endtask

  task automatic apb_write(logic [APB_ADDR_W-1:0] addr, logic [APB_DATA_W-1:0] data);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (addr == SLOPE_ADDR) begin
      slope_q = data[W-1:0];
    end
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic check_slope_readback();
    logic [APB_DATA_W-1:0] got;
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= SLOPE_ADDR;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    got = prdata;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    if (got[W-1:0] !== slope_q) begin
      report_error($sformatf("penalty_slope read %0d, held %0d",
                             $signed(got[W-1:0]), slope_q));
    end
  endtask

  task automatic set_slope(logic signed [W-1:0] slope);
    apb_write(SLOPE_ADDR, APB_DATA_W'(slope));
    check_slope_readback();
  endtask

  // reset slope, field extremes, the 4.0 boundary and segment edges
  task automatic test_reset_slope();
    logic signed [W-1:0] points [$];
    points = '{16'sd0, 16'sd1, -16'sd1, 16'sd32767, -16'sd32768, 16'sd16384, 16'sd16383,
               -16'sd16384, -16'sd16383, 16'sd256, 16'sd255, -16'sd257, 16'sd4096,
               -16'sd4096, 16'sh5555, 16'shAAAA};
    check_slope_readback();
    foreach (points[i]) send_feature(points[i]);
    drain_pipeline();
  endtask

  // most negative slope drives the penalty product into saturation
  task automatic test_slope_saturation();
    set_slope(-16'sd32768);
    send_feature(-16'sd32768);
    send_feature(-16'sd16384);
    send_feature(-16'sd1);
    send_feature(16'sd0);
    drain_pipeline();
  endtask

  // a write past the register list leaves the slope alone
  task automatic test_unmapped_write();
    apb_write(UNMAPPED_ADDR, $urandom);
    check_slope_readback();
    send_feature(-16'sd8192);
    send_feature(16'sd8192);
    drain_pipeline();
  endtask

  task automatic test_random_stream();
    logic signed [W-1:0] slopes [$];
    logic signed [W-1:0] x;
    int                  k;
    slopes = '{16'sd32767, 16'sd0, 16'sd4096, -16'sd4096, -16'sd32768, 16'sd1024};
    foreach (slopes[ph]) begin
      // one phase with a random slope, one with both sides never idling
      set_slope((ph == 3) ? W'($urandom) : slopes[ph]);
      idling_on = (ph != 2);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        case ($urandom_range(3))
          0: x = W'($urandom);
          1: x = W'($urandom_range(32767)) - 16'sd16384;
          2: begin
            // around a segment edge
            k = $urandom_range(SEGS);
            x = W'(k * (1 << (SPAN - 6)) + $urandom_range(2) - 1);
            if ($urandom_range(1)) x = -x;
          end
          default: x = W'($urandom_range(64)) - 16'sd32;
        endcase
        send_feature(x);
      end
      drain_pipeline();
    end
    idling_on = 1'b1;
  endtask

  initial begin
    build_tanh_knots();
    slope_q = W'(SLOPE_RESET);
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_n <= 1'b1;

    test_reset_slope();
    test_slope_saturation();
    test_unmapped_write();
    test_random_stream();

    repeat (LATENCY + 10) @(posedge clk_i);
    if (errors == 0 && expected_activation.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
